### src/packed_yuv422_to_rgb24_macros.svh
// Assertion helpers for the packed 4:2:2 to RGB24 converter.
`ifndef PACKED_YUV422_TO_RGB24_MACROS_SVH
`define PACKED_YUV422_TO_RGB24_MACROS_SVH

// Checked only while out of reset.
`define PKYR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PKYR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/pkyr_pkg.sv
package pkyr_pkg;

  // Default frame limits
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Queue between front and back
  localparam int FIFO_DEPTH = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_ORDER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [12:0] WIDTH_RESET  = 13'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  localparam int OFFSET_W = 26;

  // BT.601 integer coefficients
  localparam logic signed [10:0] COEF_Y   = 11'sd298;
  localparam logic signed [10:0] COEF_RV  = 11'sd409;
  localparam logic signed [10:0] COEF_GU  = 11'sd100;
  localparam logic signed [10:0] COEF_GV  = 11'sd208;
  localparam logic signed [10:0] COEF_BU  = 11'sd516;
  localparam logic signed [9:0]  LUMA_OFS   = 10'sd16;
  localparam logic signed [9:0]  CHROMA_OFS = 10'sd128;
  localparam logic signed [19:0] ROUND_ADD  = 20'sd128;

  typedef struct packed {
    logic        pixel_order;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0]          y0;
    logic [7:0]          y1;
    logic [7:0]          u;
    logic [7:0]          v;
    logic [OFFSET_W-1:0] byte_offset;
    logic                frame_end;
  } item_t;

  typedef struct packed {
    logic fresh;
    logic last_col;
    logic last_row;
  } front_stat_t;

  // Floor shift by 8 with clamp to 0..255
  function automatic logic [7:0] clamp_ch(input logic signed [19:0] t);
    logic [7:0] res;
    if (t[19]) begin
      res = 8'd0;
    end else if (|t[18:16]) begin
      res = 8'd255;
    end else begin
      res = t[15:8];
    end
    return res;
  endfunction

endpackage

### src/pkyr_front.sv
module pkyr_front
  import pkyr_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        restart,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte0,
  input  logic [7:0]  in_byte1,
  input  logic [7:0]  in_byte2,
  input  logic [7:0]  in_byte3,
  output logic        push_valid,
  input  logic        push_ready,
  output item_t       push_item,
  output front_stat_t stat
);

  localparam int COLW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH / 2) : 1;
  localparam int ROWW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [COLW-1:0]     col_r, col_nxt;
  logic [ROWW-1:0]     row_r, row_nxt;
  logic [OFFSET_W-1:0] line_r, line_nxt;
  logic                fresh_r, fresh_nxt;

  logic [13:0]         eff_w, eff_h, h_m1;
  logic [12:0]         pairs;
  logic [15:0]         stride;
  logic [29:0]         top_prod;
  logic [OFFSET_W-1:0] base, col_ofs;
  logic                last_col, last_row, accept;

  // Effective geometry from the registers
  always_comb begin
    eff_w = {1'b0, cfg.frame_width[12:1], 1'b0};
    if (eff_w < 14'd2) begin
      eff_w = 14'd2;
    end
    if (eff_w > 14'(MAX_WIDTH)) begin
      eff_w = 14'(MAX_WIDTH) & ~14'd1;
    end
    eff_h = {1'b0, cfg.frame_height};
    if (eff_h == 14'd0) begin
      eff_h = 14'd1;
    end
    if (eff_h > 14'(MAX_HEIGHT)) begin
      eff_h = 14'(MAX_HEIGHT);
    end
    pairs    = eff_w[13:1];
    h_m1     = eff_h - 14'd1;
    stride   = (16'(eff_w) * 16'd3 + 16'd3) & ~16'd3;
    top_prod = 30'(h_m1) * 30'(stride);
  end

  // Offset of this macropixel; bottom-up rows
  assign base     = fresh_r ? top_prod[OFFSET_W-1:0] : line_r;
  assign col_ofs  = OFFSET_W'({col_r, 2'b00}) + OFFSET_W'({col_r, 1'b0});
  assign last_col = (13'(col_r) == pairs - 13'd1);
  assign last_row = (14'(row_r) == h_m1);

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // Byte order select and result tags
  always_comb begin
    if (cfg.pixel_order) begin
      push_item.u  = in_byte0;
      push_item.y0 = in_byte1;
      push_item.v  = in_byte2;
      push_item.y1 = in_byte3;
    end else begin
      push_item.y0 = in_byte0;
      push_item.u  = in_byte1;
      push_item.y1 = in_byte2;
      push_item.v  = in_byte3;
    end
    push_item.byte_offset = base + col_ofs;
    push_item.frame_end   = last_col && last_row;
  end

  // Raster walk
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    line_nxt  = line_r;
    fresh_nxt = fresh_r;
    priority if (restart) begin
      col_nxt   = '0;
      row_nxt   = '0;
      fresh_nxt = 1'b1;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        if (last_row) begin
          row_nxt   = '0;
          fresh_nxt = 1'b1;
        end else begin
          row_nxt   = row_r + ROWW'(1);
          line_nxt  = base - OFFSET_W'(stride);
          fresh_nxt = 1'b0;
        end
      end else begin
        col_nxt = col_r + COLW'(1);
      end
    end else begin
      // idle: hold the walk
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      fresh_r <= 1'b1;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    line_r <= line_nxt;
  end

  assign stat.fresh    = fresh_r;
  assign stat.last_col = last_col;
  assign stat.last_row = last_row;

endmodule

### src/pkyr_fifo.sv
module pkyr_fifo
  import pkyr_pkg::*;
#(
  parameter int WIDTH = $bits(item_t),
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_pop,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  // Pointer and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### src/pkyr_convert.sv
module pkyr_convert
  import pkyr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_pop,
  input  item_t               in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_blue_first,
  output logic [7:0]          out_green_first,
  output logic [7:0]          out_red_first,
  output logic [7:0]          out_blue_second,
  output logic [7:0]          out_green_second,
  output logic [7:0]          out_red_second,
  output logic [OFFSET_W-1:0] out_byte_offset,
  output logic                out_frame_end
);

  logic signed [9:0]  c0, c1, d, e;
  logic signed [19:0] py0, py1, pbu, pgu, pgv, prv;
  logic signed [19:0] s1_py0_r, s1_py1_r, s1_pbu_r, s1_pgu_r, s1_pgv_r, s1_prv_r;
  logic [OFFSET_W-1:0] s1_ofs_r;
  logic               s1_end_r;
  logic               s1_v_r, s1_v_nxt, out_v_r, out_v_nxt;
  logic               s1_en, s2_en;
  logic signed [19:0] tb0, tg0, tr0, tb1, tg1, tr1;

  // Stage enables: a stage moves when empty or when the next one moves
  assign s2_en  = !out_v_r || out_ready;
  assign s1_en  = !s1_v_r || s2_en;
  assign in_pop = in_valid && s1_en;

  // Centered samples and products
  assign c0  = $signed({2'b00, in_item.y0}) - LUMA_OFS;
  assign c1  = $signed({2'b00, in_item.y1}) - LUMA_OFS;
  assign d   = $signed({2'b00, in_item.u}) - CHROMA_OFS;
  assign e   = $signed({2'b00, in_item.v}) - CHROMA_OFS;
  assign py0 = c0 * COEF_Y;
  assign py1 = c1 * COEF_Y;
  assign pbu = d * COEF_BU;
  assign pgu = d * COEF_GU;
  assign pgv = e * COEF_GV;
  assign prv = e * COEF_RV;

  // Channel sums
  assign tb0 = s1_py0_r + s1_pbu_r + ROUND_ADD;
  assign tg0 = s1_py0_r - s1_pgu_r - s1_pgv_r + ROUND_ADD;
  assign tr0 = s1_py0_r + s1_prv_r + ROUND_ADD;
  assign tb1 = s1_py1_r + s1_pbu_r + ROUND_ADD;
  assign tg1 = s1_py1_r - s1_pgu_r - s1_pgv_r + ROUND_ADD;
  assign tr1 = s1_py1_r + s1_prv_r + ROUND_ADD;

  assign s1_v_nxt  = s1_en ? in_valid : s1_v_r;
  assign out_v_nxt = s2_en ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Product stage
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_py0_r <= py0;
      s1_py1_r <= py1;
      s1_pbu_r <= pbu;
      s1_pgu_r <= pgu;
      s1_pgv_r <= pgv;
      s1_prv_r <= prv;
      s1_ofs_r <= in_item.byte_offset;
      s1_end_r <= in_item.frame_end;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (s2_en) begin
      out_blue_first   <= clamp_ch(tb0);
      out_green_first  <= clamp_ch(tg0);
      out_red_first    <= clamp_ch(tr0);
      out_blue_second  <= clamp_ch(tb1);
      out_green_second <= clamp_ch(tg1);
      out_red_second   <= clamp_ch(tr1);
      out_byte_offset  <= s1_ofs_r;
      out_frame_end    <= s1_end_r;
    end
  end

  assign out_valid = out_v_r;

endmodule

### src/packed_yuv422_to_rgb24.sv
// Path: an accepted request is written to the queue, then popped into the product stage,
// then held in the output register until it is taken; back-pressure can stall it.
// Throughput: one macropixel per cycle while out_ready stays high, set by the front
// counters and the one-per-cycle product stage; a two-entry queue decouples front from back.
// Reset (synchronous, rst_n low): registers return to YUY2 order, 640 x 480, the
// raster walk restarts at the bottom-up top row, and queue and pipeline empty.
module packed_yuv422_to_rgb24
  import pkyr_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte0,
  input  logic [7:0]            in_byte1,
  input  logic [7:0]            in_byte2,
  input  logic [7:0]            in_byte3,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_blue_first,
  output logic [7:0]            out_green_first,
  output logic [7:0]            out_red_first,
  output logic [7:0]            out_blue_second,
  output logic [7:0]            out_green_second,
  output logic [7:0]            out_red_second,
  output logic [OFFSET_W-1:0]   out_byte_offset,
  output logic                  out_frame_end
);

`include "packed_yuv422_to_rgb24_macros.svh"

  logic        order_r, order_nxt;
  logic [12:0] width_r, width_nxt, height_r, height_nxt;
  logic        restart;
  cfg_t        cfg;
  front_stat_t stat;
  logic        frame_done;

  logic        push_valid, push_ready, fifo_valid, fifo_pop;
  item_t       push_item, fifo_item;

  // Configuration registers; geometry writes restart the frame
  always_comb begin
    order_nxt  = order_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    restart    = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PIXEL_ORDER: begin
          order_nxt = cfg_data[0];
        end
        REG_FRAME_WIDTH: begin
          width_nxt = cfg_data;
          restart   = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          height_nxt = cfg_data;
          restart    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= 1'b0;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      order_r  <= order_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign cfg.pixel_order  = order_r;
  assign cfg.frame_width  = width_r;
  assign cfg.frame_height = height_r;

  pkyr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .restart    (restart),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte0   (in_byte0),
    .in_byte1   (in_byte1),
    .in_byte2   (in_byte2),
    .in_byte3   (in_byte3),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .stat       (stat)
  );

  pkyr_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_item),
    .rd_valid (fifo_valid),
    .rd_pop   (fifo_pop),
    .rd_data  (fifo_item)
  );

  pkyr_convert u_convert (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (fifo_valid),
    .in_pop           (fifo_pop),
    .in_item          (fifo_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_blue_first   (out_blue_first),
    .out_green_first  (out_green_first),
    .out_red_first    (out_red_first),
    .out_blue_second  (out_blue_second),
    .out_green_second (out_green_second),
    .out_red_second   (out_red_second),
    .out_byte_offset  (out_byte_offset),
    .out_frame_end    (out_frame_end)
  );

  // Last macropixel of the frame taken this cycle
  assign frame_done = in_valid && in_ready && stat.last_col && stat.last_row;

  // Checks
  `PKYR_ASSERT(a_wrap_to_top, frame_done |=> stat.fresh, "frame end did not return to top row")
  `PKYR_ASSERT(a_pop_has_data, fifo_pop |-> fifo_valid, "pop from empty queue")
  `PKYR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")

endmodule

### tb/sv/packed_yuv422_to_rgb24_check.sv
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts each converted pixel pair
// and compares it with what the converter hands out.
module packed_yuv422_to_rgb24_check
  import pkyr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_byte0,
  input  logic [7:0]            in_byte1,
  input  logic [7:0]            in_byte2,
  input  logic [7:0]            in_byte3,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_blue_first,
  input  logic [7:0]            out_green_first,
  input  logic [7:0]            out_red_first,
  input  logic [7:0]            out_blue_second,
  input  logic [7:0]            out_green_second,
  input  logic [7:0]            out_red_second,
  input  logic [OFFSET_W-1:0]   out_byte_offset,
  input  logic                  out_frame_end,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic [7:0]          blue_first;
    logic [7:0]          green_first;
    logic [7:0]          red_first;
    logic [7:0]          blue_second;
    logic [7:0]          green_second;
    logic [7:0]          red_second;
    logic [OFFSET_W-1:0] byte_offset;
    logic                frame_end;
  } bgr_pair_t;

  // Shadow registers and raster walk
  logic                order_q;
  logic [12:0]         width_q;
  logic [12:0]         height_q;
  int                  col_q;
  int                  row_q;
  logic [OFFSET_W-1:0] line_ofs_q;

  bgr_pair_t rgb_expected[$];
  int        mismatch_total = 0;
  int        pending_total  = 0;

  assign mismatches  = mismatch_total;
  assign outstanding = pending_total;

  // Even width, at least 2, saturating at the maximum
  function automatic int active_width();
    int w;
    w = int'(width_q & 13'h1FFE);
    if (w < 2) w = 2;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF & ~1;
    return w;
  endfunction

  function automatic int active_height();
    int h;
    h = int'(height_q);
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
    return h;
  endfunction

  // Row of BGR bytes padded to a multiple of 4
  function automatic int padded_stride();
    return (active_width() * 3 + 3) & ~3;
  endfunction

  // Bottom-up frame: the first row written sits at the highest offset
  function automatic void restart_walk();
    col_q      = 0;
    row_q      = 0;
    line_ofs_q = OFFSET_W'((active_height() - 1) * padded_stride());
  endfunction

  function automatic void advance_walk();
    col_q++;
    if (col_q >= active_width() / 2) begin
      col_q = 0;
      row_q++;
      if (row_q >= active_height()) begin
        restart_walk();
      end else begin
        line_ofs_q -= OFFSET_W'(padded_stride());
      end
    end
  endfunction

  // Floor divide by 256, clamp to one byte
  function automatic logic [7:0] convert_channel(input int acc);
    int q;
    if (acc < 0) return 8'd0;
    q = acc / 256;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  function automatic bgr_pair_t predict_pair(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3);
    int        y0, y1, u, v;
    int        c0, c1, d, e;
    bgr_pair_t p;
    if (order_q) begin
      u = b0; y0 = b1; v = b2; y1 = b3;
    end else begin
      y0 = b0; u = b1; y1 = b2; v = b3;
    end
    c0 = y0 - 16;
    c1 = y1 - 16;
    d  = u - 128;
    e  = v - 128;
    p.blue_first   = convert_channel(298 * c0 + 516 * d + 128);
    p.green_first  = convert_channel(298 * c0 - 100 * d - 208 * e + 128);
    p.red_first    = convert_channel(298 * c0 + 409 * e + 128);
    p.blue_second  = convert_channel(298 * c1 + 516 * d + 128);
    p.green_second = convert_channel(298 * c1 - 100 * d - 208 * e + 128);
    p.red_second   = convert_channel(298 * c1 + 409 * e + 128);
    p.byte_offset  = line_ofs_q + OFFSET_W'(6 * col_q);
    p.frame_end    = (row_q == active_height() - 1) && (col_q == active_width() / 2 - 1);
    return p;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      if (mismatch_total < 10) begin
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, want, got);
      end
      mismatch_total++;
    end
  endfunction

  always @(posedge clk) begin
    bgr_pair_t want;
    if (!rst_n) begin
      order_q  = 1'b0;
      width_q  = WIDTH_RESET;
      height_q = HEIGHT_RESET;
      restart_walk();
      rgb_expected.delete();
    end else begin
      // Register writes; geometry restarts the frame, order does not
      if (cfg_we) begin
        case (cfg_index)
          REG_PIXEL_ORDER: order_q = cfg_data[0];
          REG_FRAME_WIDTH: begin
            width_q = cfg_data;
            restart_walk();
          end
          REG_FRAME_HEIGHT: begin
            height_q = cfg_data;
            restart_walk();
          end
          default: ;
        endcase
      end

      // Result side
      if (out_valid && out_ready) begin
        if (rgb_expected.size() == 0) begin
          if (mismatch_total < 10) begin
            $display("%0t: result with no request pending", $realtime);
          end
          mismatch_total++;
        end else begin
          want = rgb_expected.pop_front();
          check_field("blue_first",   want.blue_first,   out_blue_first);
          check_field("green_first",  want.green_first,  out_green_first);
          check_field("red_first",    want.red_first,    out_red_first);
          check_field("blue_second",  want.blue_second,  out_blue_second);
          check_field("green_second", want.green_second, out_green_second);
          check_field("red_second",   want.red_second,   out_red_second);
          check_field("byte_offset",  want.byte_offset,  out_byte_offset);
          check_field("frame_end",    want.frame_end,    out_frame_end);
        end
      end

      // Request side
      if (in_valid && in_ready) begin
        rgb_expected.push_back(predict_pair(in_byte0, in_byte1, in_byte2, in_byte3));
        advance_walk();
      end
    end
    pending_total = rgb_expected.size();
  end

endmodule

### tb/sv/packed_yuv422_to_rgb24_test.sv
`timescale 1ns / 100ps

module packed_yuv422_to_rgb24_test;
  import pkyr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 40;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_byte0;
  logic [7:0]            in_byte1;
  logic [7:0]            in_byte2;
  logic [7:0]            in_byte3;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_blue_first;
  logic [7:0]            out_green_first;
  logic [7:0]            out_red_first;
  logic [7:0]            out_blue_second;
  logic [7:0]            out_green_second;
  logic [7:0]            out_red_second;
  logic [OFFSET_W-1:0]   out_byte_offset;
  logic                  out_frame_end;
  int                    mismatches;
  int                    outstanding;

  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_requests = 0;

  packed_yuv422_to_rgb24 dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte0         (in_byte0),
    .in_byte1         (in_byte1),
    .in_byte2         (in_byte2),
    .in_byte3         (in_byte3),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_blue_first   (out_blue_first),
    .out_green_first  (out_green_first),
    .out_red_first    (out_red_first),
    .out_blue_second  (out_blue_second),
    .out_green_second (out_green_second),
    .out_red_second   (out_red_second),
    .out_byte_offset  (out_byte_offset),
    .out_frame_end    (out_frame_end)
  );

  packed_yuv422_to_rgb24_check u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte0         (in_byte0),
    .in_byte1         (in_byte1),
    .in_byte2         (in_byte2),
    .in_byte3         (in_byte3),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_blue_first   (out_blue_first),
    .out_green_first  (out_green_first),
    .out_red_first    (out_red_first),
    .out_blue_second  (out_blue_second),
    .out_green_second (out_green_second),
    .out_red_second   (out_red_second),
    .out_byte_offset  (out_byte_offset),
    .out_frame_end    (out_frame_end),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard limit on the run
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random back-pressure, plus long holds on request
  initial begin
    int hold_ack;
    hold_ack  = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ack != hold_requests) begin
        hold_ack = hold_requests;
        repeat (HOLD_CYCLES) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offer one macropixel and hold it until it is taken
  task automatic send_macropixel(input logic [7:0] b0, input logic [7:0] b1,
                                 input logic [7:0] b2, input logic [7:0] b3);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte0 <= b0;
    in_byte1 <= b1;
    in_byte2 <= b2;
    in_byte3 <= b3;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait for every pending result
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly uniform, sometimes the levels where clamping and offsets matter
  function automatic logic [7:0] pick_byte();
    logic [7:0] levels [6];
    levels = '{8'd0, 8'd16, 8'd128, 8'd235, 8'd240, 8'd255};
    if ($urandom_range(0, 3) == 0) return levels[$urandom_range(0, 5)];
    return 8'($urandom);
  endfunction

  // Small frames so that ends and wraps come often, now and then anything
  function automatic logic [CFG_DATA_W-1:0] pick_width();
    if ($urandom_range(0, 7) == 0) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(0, 20));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_height();
    if ($urandom_range(0, 7) == 0) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(0, 6));
  endfunction

  // Random requests in short runs, each after a fresh register setting
  task automatic run_phase(input int tx_pct, input int rx_pct, input int total);
    int sent;
    int burst;
    bit held;
    sent = 0;
    held = 1'b0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (sent < total) begin
      drain();
      write_reg(REG_PIXEL_ORDER, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_WIDTH, pick_width());
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_HEIGHT, pick_height());
      burst = $urandom_range(8, 60);
      for (int i = 0; i < burst; i++) begin
        // stall the result side while requests keep coming
        if (!held && i == 5) begin
          hold_requests++;
          held = 1'b1;
        end
        send_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
      end
      sent += burst;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_byte0  = 8'd0;
    in_byte1  = 8'd0;
    in_byte2  = 8'd0;
    in_byte3  = 8'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_idle_pct = 10;
    rx_idle_pct = 64;

    // Reset geometry, YUY2: extremes and clamping corners
    send_macropixel(8'd0,   8'd0,   8'd0,   8'd0);
    send_macropixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_macropixel(8'd16,  8'd128, 8'd235, 8'd128);
    send_macropixel(8'd0,   8'd255, 8'd0,   8'd255);
    send_macropixel(8'd255, 8'd0,   8'd255, 8'd0);
    send_macropixel(8'd128, 8'd0,   8'd128, 8'd255);
    send_macropixel(8'd235, 8'd240, 8'd16,  8'd16);

    // Order change keeps the walk going
    drain();
    write_reg(REG_PIXEL_ORDER, 13'd1);
    send_macropixel(8'd128, 8'd16,  8'd128, 8'd235);
    send_macropixel(8'd255, 8'd0,   8'd0,   8'd255);

    // Unknown index does nothing
    drain();
    write_reg(REG_UNUSED, 13'h1FFF);
    send_macropixel(8'd128, 8'd128, 8'd128, 8'd128);

    // Odd width drops bit 0; full frame plus wrap
    drain();
    write_reg(REG_PIXEL_ORDER, 13'd0);
    write_reg(REG_FRAME_WIDTH, 13'd5);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    for (int i = 0; i < 6; i++) begin
      send_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    end

    // Zero width and height: one macropixel per frame
    drain();
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    for (int i = 0; i < 3; i++) begin
      send_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    end

    // Oversized geometry saturates
    drain();
    write_reg(REG_FRAME_WIDTH, 13'h1FFF);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    send_macropixel(8'd1, 8'd254, 8'd2, 8'd253);
    send_macropixel(8'd254, 8'd1, 8'd253, 8'd2);

    // Largest legal frame
    drain();
    write_reg(REG_FRAME_WIDTH, 13'd4096);
    write_reg(REG_FRAME_HEIGHT, 13'd4096);
    send_macropixel(8'd170, 8'd85, 8'd170, 8'd85);
    send_macropixel(8'd85, 8'd170, 8'd85, 8'd170);

    run_phase(10, 64, 300);
    run_phase(64, 10, 300);
    run_phase(0, 0, 300);

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/pkyr_pkg.sv
src/pkyr_front.sv
src/pkyr_fifo.sv
src/pkyr_convert.sv
src/packed_yuv422_to_rgb24.sv
tb/sv/packed_yuv422_to_rgb24_check.sv
tb/sv/packed_yuv422_to_rgb24_test.sv
